// ===== design/erls_pkg.sv =====
// erls_pkg: shared types and constants of the elliptic roi luma statistics block
// holds register map, configuration struct and state encodings
// used by the front, back and top modules, depends on nothing
package erls_pkg;

   // default largest frame dimension
   localparam int MAX_DIM_DEF = 4096;

   // ellipse threshold width
   localparam int THR_W = 50;

   // register port geometry
   localparam int DATA_W = 64;
   localparam int ADDR_W = 6;
   localparam int IDX_LO = 3;

   // result field widths
   localparam int Q8_W = 16;
   localparam int PCNT_W = 25;

   // register reset values
   localparam logic [12:0] FRAME_WIDTH_RST = 13'd640;
   localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

   // register index codes
   typedef enum logic [2:0] {
      REG_FRAME_WIDTH       = 3'd0,
      REG_FRAME_HEIGHT      = 3'd1,
      REG_CROP_PAD_X        = 3'd2,
      REG_CROP_PAD_Y        = 3'd3,
      REG_ELLIPSE_ENABLE    = 3'd4,
      REG_ELLIPSE_THRESHOLD = 3'd5
   } reg_idx_type;

   // configuration registers as seen by the datapath
   typedef struct packed {
      logic [12:0]      frame_width;
      logic [12:0]      frame_height;
      logic [10:0]      crop_pad_x;
      logic [10:0]      crop_pad_y;
      logic             ellipse_enable;
      logic [THR_W-1:0] ellipse_threshold;
   } cfg_type;

   // front sequencer: pixel intake and per-line geometry
   typedef enum logic [2:0] {
      FR_RUN,
      FR_GEO_A,
      FR_GEO_B,
      FR_GEO_C,
      FR_GEO_D,
      FR_GEO_DIV,
      FR_GEO_SQRT,
      FR_GEO_FIN
   } front_state_type;

   // back sequencer: frame statistics
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_LO,
      BK_MUL_HI,
      BK_MUL_SQ,
      BK_SQRT_GO,
      BK_WAIT,
      BK_STD_WAIT,
      BK_OUT
   } back_state_type;

endpackage

// ===== design/erls_div.sv =====
// erls_div: restoring divider, one quotient bit per cycle
// used by geometry and statistics paths, one instance in each, no package dependency
module erls_div #(
   parameter int NUM_W = 50,
   parameter int DEN_W = 24,
   localparam int CNT_W = $clog2(NUM_W + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quo
);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;
   logic [DEN_W-1:0] rem_in;

   // one trial subtract
   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff = trial - {1'b0, den_ff};
      ge = trial >= {1'b0, den_ff};
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // dividend shifts out, quotient shifts in
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign quo = num_ff;

endmodule

// ===== design/erls_sqrt.sv =====
// erls_sqrt: integer square root, one root bit per cycle
// digit-by-digit unit, one instance in each of front and back, no package dependency
module erls_sqrt #(
   parameter int IN_W = 50,
   localparam int RT_W = (IN_W + 1) / 2,
   localparam int PAD_W = 2 * RT_W,
   localparam int CNT_W = $clog2(RT_W + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [IN_W-1:0] radicand,
   output logic            busy,
   output logic [RT_W-1:0] root
);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [PAD_W-1:0] src_ff;
   logic [RT_W+1:0]  rem_ff;
   logic [RT_W-1:0]  root_ff;
   logic [RT_W+3:0]  rem_sh;
   logic [RT_W+3:0]  trial;
   logic             ge;
   logic [RT_W+3:0]  diff;

   // bring down two bits and try root*4+1
   always_comb begin
      rem_sh = {rem_ff, src_ff[PAD_W-1 -: 2]};
      trial = (RT_W + 4)'({root_ff, 2'b01});
      ge = rem_sh >= trial;
      diff = rem_sh - trial;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= CNT_W'(RT_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         src_ff <= PAD_W'(radicand);
         rem_ff <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         src_ff <= src_ff << 2;
         rem_ff <= ge ? diff[RT_W+1:0] : rem_sh[RT_W+1:0];
         root_ff <= {root_ff[RT_W-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== design/erls_front.sv =====
// erls_front: pixel intake, raster position, line geometry and accumulation
// depends on erls_pkg, erls_div and erls_sqrt; hands frame totals to erls_back
module erls_front #(
   parameter int MAX_DIM = erls_pkg::MAX_DIM_DEF,
   localparam int IDX_W = $clog2(MAX_DIM),
   localparam int DIM_W = IDX_W + 1,
   localparam int CNT_W = 2 * IDX_W + 1,
   localparam int SUM_W = 2 * IDX_W + 8,
   localparam int SQ_W = 2 * IDX_W + 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  erls_pkg::cfg_type    cfg,
   input  logic                 cfg_wr,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_luma,
   output logic                 push,
   input  logic                 q_full,
   output logic [CNT_W-1:0]     push_n,
   output logic [SUM_W-1:0]     push_s,
   output logic [SQ_W-1:0]      push_s2
);

   localparam int AY2_W = 2 * IDX_W;
   localparam int YY_W = 4 * IDX_W;
   localparam int THR_W = erls_pkg::THR_W;
   localparam int CMP_W = (YY_W > THR_W) ? YY_W : THR_W;
   localparam int RT_W = (THR_W + 1) / 2;
   localparam int QX_W = (RT_W + 1 > DIM_W) ? RT_W + 1 : DIM_W;

   erls_pkg::front_state_type state_ff, state_in;

   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_nx;
   logic [SQ_W-1:0]  sq_ff, sq_in, sq_nx;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_nx;
   logic [DIM_W-1:0] run_ff, run_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic             geo_ok_ff, geo_ok_in;

   // geometry working registers
   logic [IDX_W-1:0] g_padx_ff;
   logic [DIM_W-1:0] g_rw_ff;
   logic             g_inrow_ff;
   logic             g_rhone_ff;
   logic [IDX_W-1:0] g_ay_ff;
   logic [IDX_W-1:0] g_rwm1_ff;
   logic [IDX_W-1:0] g_rhm1_ff;
   logic [AY2_W-1:0] g_ay2_ff;
   logic [AY2_W-1:0] g_w2_ff;
   logic [AY2_W-1:0] g_h2_ff;
   logic [YY_W-1:0]  g_yy_ff;

   logic [DIM_W-1:0] w_eff, h_eff;
   logic [IDX_W-1:0] half_w, half_h, padx, pady, rel_r;
   logic [DIM_W-1:0] rw, rh, two_r, rhm1;
   logic             inrow;
   logic [IDX_W-1:0] ay;

   logic [CMP_W-1:0] thr_x, yy_x;
   logic             div_start, div_busy, sqrt_start, sqrt_busy;
   logic [THR_W-1:0] div_quo;
   logic [RT_W-1:0]  sqrt_root;
   logic [QX_W-1:0]  qx;

   logic             geo_ready, sel, line_end, frame_end;
   logic [15:0]      luma_sq;

   // frame dimension as used: zero reads as one, large values saturate
   function automatic logic [DIM_W-1:0] eff_dim(input logic [12:0] v);
      if (v == 13'd0) begin
         return DIM_W'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end else begin
         return DIM_W'(v);
      end
   endfunction

   // region geometry from the current registers and row
   always_comb begin
      w_eff = eff_dim(cfg.frame_width);
      h_eff = eff_dim(cfg.frame_height);
      half_w = IDX_W'((w_eff - DIM_W'(1)) >> 1);
      half_h = IDX_W'((h_eff - DIM_W'(1)) >> 1);
      padx = (32'(cfg.crop_pad_x) > 32'(half_w)) ? half_w : IDX_W'(cfg.crop_pad_x);
      pady = (32'(cfg.crop_pad_y) > 32'(half_h)) ? half_h : IDX_W'(cfg.crop_pad_y);
      rw = w_eff - {padx, 1'b0};
      rh = h_eff - {pady, 1'b0};
      rel_r = row_ff - pady;
      inrow = (row_ff >= pady) && (DIM_W'(rel_r) < rh);
      two_r = {rel_r, 1'b0};
      rhm1 = rh - DIM_W'(1);
      ay = IDX_W'((two_r >= rhm1) ? (two_r - rhm1) : (rhm1 - two_r));
      thr_x = CMP_W'(cfg.ellipse_threshold);
      yy_x = CMP_W'(g_yy_ff);
   end

   // pixel selection and totals including this pixel
   always_comb begin
      luma_sq = 16'(req_luma) * 16'(req_luma);
      sel = !cfg.ellipse_enable ||
            (run_ff != '0 && col_ff >= start_ff &&
             DIM_W'(col_ff - start_ff) < run_ff);
      sum_nx = sum_ff + (sel ? SUM_W'(req_luma) : SUM_W'(0));
      sq_nx = sq_ff + (sel ? SQ_W'(luma_sq) : SQ_W'(0));
      cnt_nx = cnt_ff + (sel ? CNT_W'(1) : CNT_W'(0));
      line_end = (DIM_W'(col_ff) + DIM_W'(1)) >= w_eff;
      frame_end = line_end && ((DIM_W'(row_ff) + DIM_W'(1)) >= h_eff);
      geo_ready = (col_ff != '0) || geo_ok_ff;
      qx = QX_W'(sqrt_root);
      if (qx[0] ^ g_rw_ff[0]) begin
         qx = qx + QX_W'(1);
      end
   end

   // sequencer next state and outputs
   always_comb begin
      state_in = state_ff;
      col_in = col_ff;
      row_in = row_ff;
      sum_in = sum_ff;
      sq_in = sq_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      start_in = start_ff;
      geo_ok_in = geo_ok_ff;
      div_start = 1'b0;
      sqrt_start = 1'b0;
      req_stall = 1'b1;
      push = 1'b0;
      unique case (state_ff)
         erls_pkg::FR_RUN: begin
            if (geo_ready && !(frame_end && q_full)) begin
               req_stall = 1'b0;
            end
            if (req_valid && !req_stall) begin
               if (line_end) begin
                  col_in = '0;
                  geo_ok_in = 1'b0;
                  if (frame_end) begin
                     row_in = '0;
                     push = 1'b1;
                     sum_in = '0;
                     sq_in = '0;
                     cnt_in = '0;
                  end else begin
                     row_in = row_ff + IDX_W'(1);
                     sum_in = sum_nx;
                     sq_in = sq_nx;
                     cnt_in = cnt_nx;
                  end
               end else begin
                  col_in = col_ff + IDX_W'(1);
                  sum_in = sum_nx;
                  sq_in = sq_nx;
                  cnt_in = cnt_nx;
               end
            end else if (req_valid && col_ff == '0 && !geo_ok_ff) begin
               state_in = erls_pkg::FR_GEO_A;
            end
         end
         erls_pkg::FR_GEO_A: state_in = erls_pkg::FR_GEO_B;
         erls_pkg::FR_GEO_B: state_in = erls_pkg::FR_GEO_C;
         erls_pkg::FR_GEO_C: state_in = erls_pkg::FR_GEO_D;
         erls_pkg::FR_GEO_D: begin
            if (!g_inrow_ff) begin
               run_in = '0;
               state_in = erls_pkg::FR_GEO_FIN;
            end else if (g_rhone_ff) begin
               run_in = g_rw_ff;
               state_in = erls_pkg::FR_GEO_FIN;
            end else if (yy_x > thr_x) begin
               run_in = '0;
               state_in = erls_pkg::FR_GEO_FIN;
            end else begin
               div_start = 1'b1;
               state_in = erls_pkg::FR_GEO_DIV;
            end
         end
         erls_pkg::FR_GEO_DIV: begin
            if (!div_busy) begin
               sqrt_start = 1'b1;
               state_in = erls_pkg::FR_GEO_SQRT;
            end
         end
         erls_pkg::FR_GEO_SQRT: begin
            if (!sqrt_busy) begin
               run_in = (qx <= QX_W'(g_rw_ff)) ? DIM_W'(qx) : g_rw_ff;
               state_in = erls_pkg::FR_GEO_FIN;
            end
         end
         erls_pkg::FR_GEO_FIN: begin
            start_in = IDX_W'(DIM_W'(g_padx_ff) + ((g_rw_ff - run_ff) >> 1));
            geo_ok_in = 1'b1;
            state_in = erls_pkg::FR_RUN;
         end
         default: state_in = erls_pkg::FR_RUN;
      endcase
      // a register write restarts any line geometry in flight
      if (cfg_wr) begin
         geo_ok_in = 1'b0;
         if (state_ff != erls_pkg::FR_RUN) begin
            state_in = erls_pkg::FR_RUN;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= erls_pkg::FR_RUN;
         col_ff <= '0;
         row_ff <= '0;
         sum_ff <= '0;
         sq_ff <= '0;
         cnt_ff <= '0;
         run_ff <= '0;
         start_ff <= '0;
         geo_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         row_ff <= row_in;
         sum_ff <= sum_in;
         sq_ff <= sq_in;
         cnt_ff <= cnt_in;
         run_ff <= run_in;
         start_ff <= start_in;
         geo_ok_ff <= geo_ok_in;
      end
   end

   // geometry pipeline registers
   always_ff @(posedge clock) begin
      if (state_ff == erls_pkg::FR_GEO_A) begin
         g_padx_ff <= padx;
         g_rw_ff <= rw;
         g_inrow_ff <= inrow;
         g_rhone_ff <= (rh == DIM_W'(1));
         g_ay_ff <= ay;
         g_rwm1_ff <= IDX_W'(rw - DIM_W'(1));
         g_rhm1_ff <= IDX_W'(rhm1);
      end
      if (state_ff == erls_pkg::FR_GEO_B) begin
         g_ay2_ff <= AY2_W'(g_ay_ff) * AY2_W'(g_ay_ff);
         g_w2_ff <= AY2_W'(g_rwm1_ff) * AY2_W'(g_rwm1_ff);
         g_h2_ff <= AY2_W'(g_rhm1_ff) * AY2_W'(g_rhm1_ff);
      end
      if (state_ff == erls_pkg::FR_GEO_C) begin
         g_yy_ff <= YY_W'(g_ay2_ff) * YY_W'(g_w2_ff);
      end
   end

   // (threshold - y^2*w2) / h2, then its square root
   erls_div #(
      .NUM_W(THR_W),
      .DEN_W(AY2_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (THR_W'(thr_x - yy_x)),
      .den   (g_h2_ff),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   erls_sqrt #(
      .IN_W(THR_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_quo),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   assign push_n = cnt_nx;
   assign push_s = sum_nx;
   assign push_s2 = sq_nx;

   // checks
   a_stall_in_geo: assert property (@(posedge clock) disable iff (reset)
      state_ff != erls_pkg::FR_RUN |-> req_stall)
      else $error("word taken while line geometry runs");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("frame totals pushed into a full queue");

   a_run_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == erls_pkg::FR_GEO_FIN |-> run_ff <= g_rw_ff)
      else $error("line run wider than region");

endmodule

// ===== design/erls_back.sv =====
// erls_back: frame totals queue, mean and deviation sequencer, result register
// depends on erls_pkg, erls_div and erls_sqrt; fed by erls_front
module erls_back #(
   parameter int MAX_DIM = erls_pkg::MAX_DIM_DEF,
   localparam int IDX_W = $clog2(MAX_DIM),
   localparam int CNT_W = 2 * IDX_W + 1,
   localparam int SUM_W = 2 * IDX_W + 8,
   localparam int SQ_W = 2 * IDX_W + 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          q_full,
   input  logic [CNT_W-1:0]              push_n,
   input  logic [SUM_W-1:0]              push_s,
   input  logic [SQ_W-1:0]               push_s2,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [erls_pkg::Q8_W-1:0]     rsp_mean_q8,
   output logic [erls_pkg::Q8_W-1:0]     rsp_std_dev_q8,
   output logic [erls_pkg::PCNT_W-1:0]   rsp_pixel_count,
   output logic                          rsp_empty_res
);

   localparam int DW = CNT_W + SQ_W;
   localparam int HALF = (SQ_W + 1) / 2;
   localparam int MUL_W0 = (SUM_W > CNT_W) ? SUM_W : CNT_W;
   localparam int MUL_W = (MUL_W0 > HALF) ? MUL_W0 : HALF;
   localparam int TW = DW + 18;
   localparam int RT_W = (TW + 1) / 2;
   localparam int MN_W = SUM_W + 9;
   localparam int SN_W = ((RT_W > CNT_W) ? RT_W : CNT_W) + 1;
   localparam int DNUM_W = (MN_W > SN_W) ? MN_W : SN_W;
   localparam int DDEN_W = CNT_W + 1;
   localparam int Q8_W = erls_pkg::Q8_W;
   localparam int PCNT_W = erls_pkg::PCNT_W;

   // two-entry queue of frame totals
   logic [CNT_W-1:0] qn_ff [2];
   logic [SUM_W-1:0] qs_ff [2];
   logic [SQ_W-1:0]  qs2_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       q_cnt_ff;
   logic             pop;

   erls_pkg::back_state_type state_ff, state_in;

   logic [CNT_W-1:0] n_ff;
   logic [SUM_W-1:0] s_ff;
   logic [SQ_W-1:0]  s2_ff;
   logic [DW-1:0]    acc_ff, acc_in;
   logic [Q8_W-1:0]  mean_ff, mean_in;
   logic             empty_ff, empty_in;

   logic             rsp_valid_ff;
   logic [Q8_W-1:0]  rsp_mean_ff, rsp_std_ff;
   logic [PCNT_W-1:0] rsp_cnt_ff;
   logic             rsp_empty_ff;
   logic             out_free, load;

   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] prod;

   logic              div_start, div_busy, sqrt_start, sqrt_busy;
   logic [DNUM_W-1:0] div_num, div_quo;
   logic [DDEN_W-1:0] div_den;
   logic [RT_W-1:0]   sqrt_root;

   assign q_full = (q_cnt_ff == 2'd2);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // shared multiplier operand select
   always_comb begin
      mul_a = MUL_W'(n_ff);
      mul_b = MUL_W'(s2_ff[HALF-1:0]);
      unique case (state_ff)
         erls_pkg::BK_MUL_HI: mul_b = MUL_W'(s2_ff[SQ_W-1:HALF]);
         erls_pkg::BK_MUL_SQ: begin
            mul_a = MUL_W'(s_ff);
            mul_b = MUL_W'(s_ff);
         end
         default: ;
      endcase
      prod = (2 * MUL_W)'(mul_a) * (2 * MUL_W)'(mul_b);
   end

   // sequencer next state and outputs
   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      mean_in = mean_ff;
      empty_in = empty_ff;
      pop = 1'b0;
      load = 1'b0;
      div_start = 1'b0;
      sqrt_start = 1'b0;
      div_num = DNUM_W'({s_ff, 8'b0}) + DNUM_W'(n_ff >> 1);
      div_den = DDEN_W'(n_ff);
      unique case (state_ff)
         erls_pkg::BK_IDLE: begin
            if (q_cnt_ff != 2'd0) begin
               pop = 1'b1;
               empty_in = (qn_ff[rd_ptr_ff] == '0);
               state_in = (qn_ff[rd_ptr_ff] == '0) ? erls_pkg::BK_OUT
                                                   : erls_pkg::BK_MUL_LO;
            end
         end
         erls_pkg::BK_MUL_LO: begin
            acc_in = DW'(prod);
            state_in = erls_pkg::BK_MUL_HI;
         end
         erls_pkg::BK_MUL_HI: begin
            acc_in = acc_ff + (DW'(prod) << HALF);
            state_in = erls_pkg::BK_MUL_SQ;
         end
         erls_pkg::BK_MUL_SQ: begin
            // n*s2 - s*s, and mean = (256*s + n/2) / n starts alongside
            acc_in = acc_ff - DW'(prod);
            div_start = 1'b1;
            state_in = erls_pkg::BK_SQRT_GO;
         end
         erls_pkg::BK_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in = erls_pkg::BK_WAIT;
         end
         erls_pkg::BK_WAIT: begin
            // deviation = (isqrt(D << 18) + n) / (2n)
            if (!div_busy && !sqrt_busy) begin
               mean_in = Q8_W'(div_quo);
               div_num = DNUM_W'(sqrt_root) + DNUM_W'(n_ff);
               div_den = {n_ff, 1'b0};
               div_start = 1'b1;
               state_in = erls_pkg::BK_STD_WAIT;
            end
         end
         erls_pkg::BK_STD_WAIT: begin
            if (!div_busy) begin
               state_in = erls_pkg::BK_OUT;
            end
         end
         erls_pkg::BK_OUT: begin
            if (out_free) begin
               load = 1'b1;
               state_in = erls_pkg::BK_IDLE;
            end
         end
         default: state_in = erls_pkg::BK_IDLE;
      endcase
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         qn_ff[wr_ptr_ff] <= push_n;
         qs_ff[wr_ptr_ff] <= push_s;
         qs2_ff[wr_ptr_ff] <= push_s2;
      end
   end

   // queue pointers and sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         q_cnt_ff <= 2'd0;
         state_ff <= erls_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            q_cnt_ff <= q_cnt_ff + 2'd1;
         end else if (pop && !push) begin
            q_cnt_ff <= q_cnt_ff - 2'd1;
         end
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working totals and result register
   always_ff @(posedge clock) begin
      if (pop) begin
         n_ff <= qn_ff[rd_ptr_ff];
         s_ff <= qs_ff[rd_ptr_ff];
         s2_ff <= qs2_ff[rd_ptr_ff];
      end
      acc_ff <= acc_in;
      mean_ff <= mean_in;
      empty_ff <= empty_in;
      if (load) begin
         rsp_mean_ff <= empty_ff ? '0 : mean_ff;
         rsp_std_ff <= empty_ff ? '0 : Q8_W'(div_quo);
         rsp_cnt_ff <= PCNT_W'(n_ff);
         rsp_empty_ff <= empty_ff;
      end
   end

   erls_div #(
      .NUM_W(DNUM_W),
      .DEN_W(DDEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   erls_sqrt #(
      .IN_W(TW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({acc_ff, 18'b0}),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mean_q8 = rsp_mean_ff;
   assign rsp_std_dev_q8 = rsp_std_ff;
   assign rsp_pixel_count = rsp_cnt_ff;
   assign rsp_empty_res = rsp_empty_ff;

   // checks
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff != 2'd3)
      else $error("totals queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> q_cnt_ff != 2'd2)
      else $error("totals queue overflow");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |->
         rsp_mean_ff == '0 && rsp_std_ff == '0 && rsp_cnt_ff == '0)
      else $error("empty result with nonzero fields");

endmodule

// ===== design/elliptic_roi_luma_statistics.sv =====
// elliptic_roi_luma_statistics: top level, register port and front/back wiring
// depends on erls_pkg, erls_front and erls_back
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_luma
//   rsp       out        rsp_valid/rsp_stall  rsp_mean_q8, rsp_std_dev_q8,
//                                             rsp_pixel_count, rsp_empty_res
//   csr       in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// one pixel word per cycle inside a line while the totals queue has room at the
// last pixel of a frame; the first pixel of each line is stalled while the front
// computes the line run (region geometry, squares, product, threshold compare, then
// divider and square root when a division is needed); per frame the back runs a
// square root and two divides, the first overlapped, and works while the next frame streams in
// synchronous active-high reset; no clearing pass
// either side may stall on its own: a two-entry totals queue and the result
// register part the pixel stream from the statistics sequencer
module elliptic_roi_luma_statistics #(
   parameter int MAX_DIM = erls_pkg::MAX_DIM_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_luma,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [erls_pkg::Q8_W-1:0]      rsp_mean_q8,
   output logic [erls_pkg::Q8_W-1:0]      rsp_std_dev_q8,
   output logic [erls_pkg::PCNT_W-1:0]    rsp_pixel_count,
   output logic                           rsp_empty_res,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [erls_pkg::ADDR_W-1:0]    paddr,
   input  logic [erls_pkg::DATA_W-1:0]    pwdata,
   output logic [erls_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int CNT_W = 2 * IDX_W + 1;
   localparam int SUM_W = 2 * IDX_W + 8;
   localparam int SQ_W = 2 * IDX_W + 16;
   localparam int DATA_W = erls_pkg::DATA_W;
   localparam int ADDR_W = erls_pkg::ADDR_W;
   localparam int IDX_LO = erls_pkg::IDX_LO;

   erls_pkg::cfg_type     cfg_ff;
   erls_pkg::reg_idx_type reg_idx;
   logic                  cfg_wr;

   logic             push, q_full;
   logic [CNT_W-1:0] push_n;
   logic [SUM_W-1:0] push_s;
   logic [SQ_W-1:0]  push_s2;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign reg_idx = erls_pkg::reg_idx_type'(paddr[ADDR_W-1:IDX_LO]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width <= erls_pkg::FRAME_WIDTH_RST;
         cfg_ff.frame_height <= erls_pkg::FRAME_HEIGHT_RST;
         cfg_ff.crop_pad_x <= '0;
         cfg_ff.crop_pad_y <= '0;
         cfg_ff.ellipse_enable <= 1'b0;
         cfg_ff.ellipse_threshold <= '0;
      end else if (cfg_wr) begin
         unique case (reg_idx)
            erls_pkg::REG_FRAME_WIDTH:       cfg_ff.frame_width <= pwdata[12:0];
            erls_pkg::REG_FRAME_HEIGHT:      cfg_ff.frame_height <= pwdata[12:0];
            erls_pkg::REG_CROP_PAD_X:        cfg_ff.crop_pad_x <= pwdata[10:0];
            erls_pkg::REG_CROP_PAD_Y:        cfg_ff.crop_pad_y <= pwdata[10:0];
            erls_pkg::REG_ELLIPSE_ENABLE:    cfg_ff.ellipse_enable <= pwdata[0];
            erls_pkg::REG_ELLIPSE_THRESHOLD: begin
               cfg_ff.ellipse_threshold <= pwdata[erls_pkg::THR_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_idx)
         erls_pkg::REG_FRAME_WIDTH:       prdata = DATA_W'(cfg_ff.frame_width);
         erls_pkg::REG_FRAME_HEIGHT:      prdata = DATA_W'(cfg_ff.frame_height);
         erls_pkg::REG_CROP_PAD_X:        prdata = DATA_W'(cfg_ff.crop_pad_x);
         erls_pkg::REG_CROP_PAD_Y:        prdata = DATA_W'(cfg_ff.crop_pad_y);
         erls_pkg::REG_ELLIPSE_ENABLE:    prdata = DATA_W'(cfg_ff.ellipse_enable);
         erls_pkg::REG_ELLIPSE_THRESHOLD: prdata = DATA_W'(cfg_ff.ellipse_threshold);
         default:                         prdata = '0;
      endcase
   end

   // pixel intake and line geometry
   erls_front #(
      .MAX_DIM(MAX_DIM)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cfg_wr    (cfg_wr),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_luma  (req_luma),
      .push      (push),
      .q_full    (q_full),
      .push_n    (push_n),
      .push_s    (push_s),
      .push_s2   (push_s2)
   );

   // frame statistics
   erls_back #(
      .MAX_DIM(MAX_DIM)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .q_full          (q_full),
      .push_n          (push_n),
      .push_s          (push_s),
      .push_s2         (push_s2),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_mean_q8     (rsp_mean_q8),
      .rsp_std_dev_q8  (rsp_std_dev_q8),
      .rsp_pixel_count (rsp_pixel_count),
      .rsp_empty_res   (rsp_empty_res)
   );

endmodule
